// ===== rtl/core/tdr_pkg.sv =====
// Shared types and constants of the tap-dance resolver.
package tdr_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] REQ_DOWN = 2'd0;
	localparam logic [1:0] REQ_UP   = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [1:0] KIND_PRESS   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_FULL    = 2'd2;
	localparam logic [1:0] KIND_ORPHAN  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TAPPING_TERM = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 1'd1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  position;
		logic        is_dance_key;
		logic [31:0] now_ms;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  binding_index;
		logic [7:0]  key_position;
		logic [31:0] event_time;
		logic        last;
	} res_word_t;

	typedef struct packed {
		logic [7:0]  key;
		logic [3:0]  taps;
		logic        held;
		logic        decided;
		logic [31:0] deadline;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_EV,
		S_A_REL,
		S_F_RD,
		S_F_EV,
		S_DOWN,
		S_UP,
		S_T_RD,
		S_T_EV,
		S_T_REL,
		S_DONE
	} state_t;

endpackage

// ===== rtl/core/tdr_if.sv =====
// Valid-ready channels that carry request and result words.
interface tdr_req_if;
	logic valid;
	logic ready;
	tdr_pkg::req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tdr_res_if;
	logic valid;
	logic ready;
	tdr_pkg::res_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tap_dance_resolver.sv =====
// Tap-dance resolver top level with the entry memory and its sequencer.
// The block takes one request word at a time and walks the entry table one entry at a
// time through a synchronous memory with a registered read: a free entry is skipped
// without a read, a used one is read and then evaluated, and an expired entry on a tick
// is also released unless it is still held. A key-down can scan the table twice, and
// the result side can stall the walk. Results leave through an output register; the
// last result of a request carries last. Used and armed bits live in flip-flops
// cleared by reset.
module tap_dance_resolver #(
	parameter int ENTRIES = 8,
	parameter int MAX_BINDINGS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tdr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tdr_pkg::CFG_DATA_W-1:0] cfg_data,
	tdr_req_if.sink                        req,
	tdr_res_if.source                      res
);
	import tdr_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IW = $clog2(ENTRIES + 1);

	entry_t mem_q [ENTRIES];
	entry_t rd_q;

	state_t state_q, nxt;
	logic [15:0] term_q;
	logic [3:0] tapc_q;
	req_word_t rq_q;
	logic [IW-1:0] idx_q, idx_d;
	logic [4:0] n_q;
	logic [ENTRIES-1:0] used_q, used_d, armed_q, armed_d;
	logic found_q, found_d, free_v_q, free_v_d;
	logic [AW-1:0] free_q, free_d;
	res_word_t pend_q, out_q, ew;
	logic pend_v_q, out_v_q;

	logic [AW-1:0] cur, ea, wa;
	logic at_end, emit, go, can_push, push_out, we, rd_en;
	entry_t wd, base;
	logic [3:0] cnt, tnew;
	logic [31:0] diff;

	assign cur = idx_q[AW-1:0];
	assign at_end = (idx_q == IW'(ENTRIES));
	assign can_push = !out_v_q || res.ready;
	assign req.ready = (state_q == S_IDLE);
	assign res.valid = out_v_q;
	assign res.data = out_q;
	assign diff = rq_q.now_ms - rd_q.deadline;

	always_comb begin
		if (tapc_q == 4'd0) begin
			cnt = 4'd1;
		end else if (tapc_q > 4'(MAX_BINDINGS)) begin
			cnt = 4'(MAX_BINDINGS);
		end else begin
			cnt = tapc_q;
		end
	end

	always_comb begin
		nxt = state_q;
		idx_d = idx_q;
		used_d = used_q;
		armed_d = armed_q;
		found_d = found_q;
		free_v_d = free_v_q;
		free_d = free_q;
		emit = 1'b0;
		ew = '0;
		we = 1'b0;
		wa = cur;
		wd = rd_q;
		rd_en = 1'b0;
		ea = cur;
		base = rd_q;
		tnew = 4'd0;
		unique case (state_q)
			S_IDLE: begin
				idx_d = '0;
				found_d = 1'b0;
				free_v_d = 1'b0;
				if (req.valid) begin
					unique case (req.data.req_type)
						REQ_DOWN: nxt = S_A_RD;
						REQ_UP: nxt = req.data.is_dance_key ? S_F_RD : S_DONE;
						REQ_TICK: nxt = S_T_RD;
						default: nxt = S_DONE;
					endcase
				end
			end
			S_A_RD: begin
				if (at_end) begin
					idx_d = '0;
					nxt = rq_q.is_dance_key ? S_F_RD : S_DONE;
				end else if (!used_q[cur]) begin
					idx_d = IW'(idx_q + 1'b1);
				end else begin
					rd_en = 1'b1;
					nxt = S_A_EV;
				end
			end
			S_A_EV: begin
				if (rd_q.key != rq_q.position) begin
					armed_d[cur] = 1'b0;
					if (!rd_q.decided) begin
						we = 1'b1;
						wd.decided = 1'b1;
						emit = 1'b1;
						ew = '{KIND_PRESS, 3'(rd_q.taps - 4'd1), rd_q.key, rq_q.now_ms, 1'b0};
						if (rd_q.held) begin
							idx_d = '0;
							nxt = rq_q.is_dance_key ? S_F_RD : S_DONE;
						end else begin
							nxt = S_A_REL;
						end
					end else begin
						idx_d = IW'(idx_q + 1'b1);
						nxt = S_A_RD;
					end
				end else begin
					idx_d = IW'(idx_q + 1'b1);
					nxt = S_A_RD;
				end
			end
			S_A_REL: begin
				emit = 1'b1;
				ew = '{KIND_RELEASE, 3'(rd_q.taps - 4'd1), rd_q.key, rq_q.now_ms, 1'b0};
				used_d[cur] = 1'b0;
				armed_d[cur] = 1'b0;
				idx_d = '0;
				nxt = rq_q.is_dance_key ? S_F_RD : S_DONE;
			end
			S_F_RD: begin
				if (at_end) begin
					nxt = (rq_q.req_type == REQ_DOWN) ? S_DOWN : S_UP;
				end else if (!used_q[cur]) begin
					if (!free_v_q) begin
						free_v_d = 1'b1;
						free_d = cur;
					end
					idx_d = IW'(idx_q + 1'b1);
				end else begin
					rd_en = 1'b1;
					nxt = S_F_EV;
				end
			end
			S_F_EV: begin
				if (rd_q.key == rq_q.position) begin
					found_d = 1'b1;
					nxt = (rq_q.req_type == REQ_DOWN) ? S_DOWN : S_UP;
				end else begin
					idx_d = IW'(idx_q + 1'b1);
					nxt = S_F_RD;
				end
			end
			S_DOWN: begin
				nxt = S_DONE;
				if (!found_q && !free_v_q) begin
					emit = 1'b1;
					ew = '{KIND_FULL, 3'd0, rq_q.position, rq_q.now_ms, 1'b0};
				end else begin
					ea = found_q ? cur : free_q;
					if (!found_q) begin
						base.key = rq_q.position;
						base.taps = 4'd0;
						base.decided = 1'b0;
					end
					base.held = 1'b1;
					tnew = (base.taps < cnt) ? base.taps + 4'd1 : base.taps;
					base.taps = tnew;
					used_d[ea] = 1'b1;
					if (tnew == cnt) begin
						base.decided = 1'b1;
						armed_d[ea] = 1'b0;
						emit = 1'b1;
						ew = '{KIND_PRESS, 3'(tnew - 4'd1), rq_q.position, rq_q.now_ms, 1'b0};
					end else begin
						base.deadline = rq_q.now_ms + 32'(term_q);
						armed_d[ea] = 1'b1;
					end
					we = 1'b1;
					wa = ea;
					wd = base;
				end
			end
			S_UP: begin
				nxt = S_DONE;
				if (!found_q) begin
					emit = 1'b1;
					ew = '{KIND_ORPHAN, 3'd0, rq_q.position, rq_q.now_ms, 1'b0};
				end else begin
					we = 1'b1;
					wd.held = 1'b0;
					if (rd_q.decided) begin
						emit = 1'b1;
						ew = '{KIND_RELEASE, 3'(rd_q.taps - 4'd1), rq_q.position,
							rq_q.now_ms, 1'b0};
						used_d[cur] = 1'b0;
						armed_d[cur] = 1'b0;
					end
				end
			end
			S_T_RD: begin
				if (at_end || n_q >= 5'(MAX_RESULTS - 1)) begin
					nxt = S_DONE;
				end else if (!(used_q[cur] && armed_q[cur])) begin
					idx_d = IW'(idx_q + 1'b1);
				end else begin
					rd_en = 1'b1;
					nxt = S_T_EV;
				end
			end
			S_T_EV: begin
				if (!diff[31]) begin
					armed_d[cur] = 1'b0;
					we = 1'b1;
					wd.decided = 1'b1;
					emit = 1'b1;
					ew = '{KIND_PRESS, 3'(rd_q.taps - 4'd1), rd_q.key, rd_q.deadline, 1'b0};
					if (rd_q.held) begin
						idx_d = IW'(idx_q + 1'b1);
						nxt = S_T_RD;
					end else begin
						nxt = S_T_REL;
					end
				end else begin
					idx_d = IW'(idx_q + 1'b1);
					nxt = S_T_RD;
				end
			end
			S_T_REL: begin
				emit = 1'b1;
				ew = '{KIND_RELEASE, 3'(rd_q.taps - 4'd1), rd_q.key, rd_q.deadline, 1'b0};
				used_d[cur] = 1'b0;
				armed_d[cur] = 1'b0;
				idx_d = IW'(idx_q + 1'b1);
				nxt = S_T_RD;
			end
			S_DONE: begin
				nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	// A new result moves the staged one to the output, so the final one can be marked last.
	assign go = (state_q == S_DONE || emit) ? (!pend_v_q || can_push) : 1'b1;
	assign push_out = go && pend_v_q && (emit || state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			term_q <= 16'd200;
			tapc_q <= 4'd1;
			used_q <= '0;
			armed_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
			idx_q <= '0;
			n_q <= '0;
			found_q <= 1'b0;
			free_v_q <= 1'b0;
			free_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TAPPING_TERM: term_q <= cfg_data;
					REG_TAP_COUNT: tapc_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (push_out) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
			if (go) begin
				state_q <= nxt;
				idx_q <= idx_d;
				used_q <= used_d;
				armed_q <= armed_d;
				found_q <= found_d;
				free_v_q <= free_v_d;
				free_q <= free_d;
				if (state_q == S_IDLE) begin
					n_q <= '0;
				end else if (emit) begin
					n_q <= n_q + 5'd1;
				end
				if (emit) begin
					pend_v_q <= 1'b1;
				end else if (state_q == S_DONE) begin
					pend_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			rq_q <= req.data;
		end
		if (go && emit) begin
			pend_q <= ew;
		end
		if (push_out) begin
			out_q <= '{kind: pend_q.kind, binding_index: pend_q.binding_index,
				key_position: pend_q.key_position, event_time: pend_q.event_time,
				last: (state_q == S_DONE)};
		end
	end

	always_ff @(posedge clk) begin
		if (go && we) begin
			mem_q[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem_q[cur];
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> !pend_v_q)
		else $error("request taken while a result is still staged");

	a_tick_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_T_EV) |-> (used_q[cur] && armed_q[cur]))
		else $error("deadline checked on an entry that is not armed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 5'(MAX_RESULTS))
		else $error("too many results for one request");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push_out && state_q != S_DONE) |=> !res.data.last)
		else $error("last set on a result that is not final");

endmodule
